>>> rtl/alat_pkg.sv
// shared types and constants of the alert latch and acknowledge table
// no dependencies

package alat_pkg;

  typedef enum logic [1:0] {
    F_SET     = 2'd0,
    F_CLR_ONE = 2'd1,
    F_CLR_ALL = 2'd2,
    F_ACK_ALL = 2'd3
  } alat_func_e;

  localparam logic [1:0] LVL_WARNING = 2'd0;
  localparam logic [1:0] LVL_CAUTION = 2'd1;

  typedef struct packed {
    alat_func_e func;
    logic [7:0] alert_id;
    logic [1:0] alert_level;
    logic       cond_present;
    logic       latch_req;
  } alat_in_t;

  typedef struct packed {
    logic became_shown;
    logic became_hidden;
    logic table_full;
    logic master_warning;
    logic master_caution;
  } alat_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } alat_state_e;

  // flags of one entry as seen by the scan unit
  typedef struct packed {
    logic valid;
    logic active;
    logic latched;
    logic acked;
  } alat_flags_t;

  // accumulated scan outcome
  typedef struct packed {
    logic       hit;
    logic       free;
    logic       warn;
    logic       caut;
    logic [1:0] hit_sev;
  } alat_scan_t;

endpackage

>>> rtl/alat_id_mem.sv
// id and severity store of the alert table, one write and one registered read port
// depends on nothing but its parameters

module alat_id_mem #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 8,
  parameter int IDX_W   = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ID_BITS-1:0] wr_ident,
  input  logic [1:0]         wr_sev,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ID_BITS-1:0] rd_ident,
  output logic [1:0]         rd_sev
);

  logic [ID_BITS+1:0] mem [ENTRIES];
  logic [ID_BITS+1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ident, wr_sev};
    end
  end

  always_ff @(posedge clk) begin
    rd_word_r <= mem[rd_addr];
  end

  assign rd_ident = rd_word_r[ID_BITS+1:2];
  assign rd_sev   = rd_word_r[1:0];

endmodule

>>> rtl/alat_scan.sv
// shared per-entry compare unit: id match, first free slot and pending levels
// depends on alat_pkg

module alat_scan #(
  parameter int ID_BITS = 8,
  parameter int IDX_W   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 step,
  input  alat_pkg::alat_func_e func,
  input  logic [ID_BITS-1:0]   key,
  input  alat_pkg::alat_flags_t flags,
  input  logic [ID_BITS-1:0]   ident,
  input  logic [1:0]           sev,
  input  logic [IDX_W-1:0]     idx,
  output alat_pkg::alat_scan_t res,
  output logic [IDX_W-1:0]     hit_idx,
  output logic [IDX_W-1:0]     free_idx
);
  import alat_pkg::*;

  alat_scan_t       res_r, res_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             match, lookup, shown_post, acked_post, pend;

  always_comb begin
    lookup     = (func == F_SET) || (func == F_CLR_ONE);
    match      = flags.valid && (ident == key);
    // flags as they stand once the item has taken effect
    shown_post = (func == F_CLR_ALL) ? flags.active : (flags.active | flags.latched);
    acked_post = (func == F_ACK_ALL) ? (flags.acked | shown_post) : flags.acked;
    // the looked-up entry is counted after its update instead
    pend       = flags.valid && shown_post && !acked_post && !(lookup && match);

    res_nxt      = res_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    if (clr) begin
      res_nxt = '0;
    end else if (step) begin
      if (lookup && match && !res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_sev = sev;
        hit_idx_nxt     = idx;
      end
      if (!flags.valid && !res_r.free) begin
        res_nxt.free = 1'b1;
        free_idx_nxt = idx;
      end
      if (pend && sev == LVL_WARNING) res_nxt.warn = 1'b1;
      if (pend && sev == LVL_CAUTION) res_nxt.caut = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign res      = res_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;

endmodule

>>> rtl/alert_latch_ack_table.sv
// top level of the alert latch and acknowledge table: sequencer, entry flags, result register
// depends on alat_pkg, alat_id_mem and alat_scan

// Annunciator table of ENTRIES alerts looked up by id. Each item walks the table
// once through a single compare unit, one entry per clock, reading ids and
// severities from a registered-read memory; the walk finds the entry, the first
// free slot and the pending warning and caution levels of all other entries.
// The update state then writes the entry and forms the result, and the done
// state moves it to the output register once that is free. in_stall is high
// while an item is in work, so a result waiting in the done state on out_stall
// holds back the next input transfer.

module alert_latch_ack_table #(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  alat_pkg::alat_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output alat_pkg::alat_out_t out_data
);
  import alat_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ENTRIES);

  alat_state_e        state_r, state_nxt;
  alat_in_t           item_r, item_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] active_r, active_nxt;
  logic [ENTRIES-1:0] latched_r, latched_nxt;
  logic [ENTRIES-1:0] acked_r, acked_nxt;
  alat_out_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  alat_out_t          out_r, out_nxt;

  logic               scan_clr;
  alat_flags_t        scan_flags;
  alat_scan_t         scan_res;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic [ID_BITS-1:0] rd_ident;
  logic [1:0]         rd_sev;
  logic               mem_wr;

  logic [IDX_W-1:0]   sel;
  logic               old_a, old_l, old_k;
  logic               new_a, new_l, new_k;
  logic               shown_before, shown_after;
  logic               pk;
  logic [1:0]         pk_sev;
  logic               warn;

  alat_id_mem #(
    .ENTRIES(ENTRIES),
    .ID_BITS(ID_BITS),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (sel),
    .wr_ident(key_r),
    .wr_sev  (item_r.alert_level),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_ident(rd_ident),
    .rd_sev  (rd_sev)
  );

  assign scan_flags.valid   = valid_r[rd_idx_r];
  assign scan_flags.active  = active_r[rd_idx_r];
  assign scan_flags.latched = latched_r[rd_idx_r];
  assign scan_flags.acked   = acked_r[rd_idx_r];

  alat_scan #(
    .ID_BITS(ID_BITS),
    .IDX_W  (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (scan_clr),
    .step    (rd_vld_r),
    .func    (item_r.func),
    .key     (key_r),
    .flags   (scan_flags),
    .ident   (rd_ident),
    .sev     (rd_sev),
    .idx     (rd_idx_r),
    .res     (scan_res),
    .hit_idx (hit_idx),
    .free_idx(free_idx)
  );

  // entry named by the item: the match, else the lowest free slot
  always_comb begin
    sel          = scan_res.hit ? hit_idx : free_idx;
    old_a        = scan_res.hit && active_r[sel];
    old_l        = scan_res.hit && latched_r[sel];
    old_k        = scan_res.hit && acked_r[sel];
    new_a        = item_r.cond_present;
    new_l        = old_l | (item_r.cond_present & item_r.latch_req);
    shown_before = old_a | old_l;
    shown_after  = new_a | new_l;
    new_k        = (!shown_before && shown_after) ? 1'b0 : old_k;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    valid_nxt     = valid_r;
    active_nxt    = active_r;
    latched_nxt   = latched_r;
    acked_nxt     = acked_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    scan_clr      = 1'b0;
    mem_wr        = 1'b0;
    pk            = 1'b0;
    pk_sev        = item_r.alert_level;
    warn          = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          key_nxt   = ID_BITS'(in_data.alert_id);
          cnt_nxt   = '0;
          scan_clr  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // memory read data comes in the cycle after its address
        rd_idx_nxt = cnt_r[IDX_W-1:0];
        if (cnt_r == LAST) begin
          state_nxt = S_UPDATE;
        end else begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      S_UPDATE: begin
        res_nxt = '0;
        case (item_r.func)
          F_SET: begin
            if (scan_res.hit || scan_res.free) begin
              valid_nxt[sel]      = 1'b1;
              active_nxt[sel]     = new_a;
              latched_nxt[sel]    = new_l;
              acked_nxt[sel]      = new_k;
              mem_wr              = 1'b1;
              res_nxt.became_shown  = !shown_before && shown_after;
              res_nxt.became_hidden = shown_before && !shown_after;
              pk                  = shown_after && !new_k;
              pk_sev              = item_r.alert_level;
            end else begin
              res_nxt.table_full = 1'b1;
            end
          end
          F_CLR_ONE: begin
            if (scan_res.hit) begin
              latched_nxt[hit_idx] = 1'b0;
              if (!active_r[hit_idx]) acked_nxt[hit_idx] = 1'b0;
              pk     = active_r[hit_idx] && acked_r[hit_idx] == 1'b0;
              pk_sev = scan_res.hit_sev;
            end
          end
          F_CLR_ALL: begin
            latched_nxt = '0;
          end
          F_ACK_ALL: begin
            acked_nxt = acked_r | (valid_r & (active_r | latched_r));
          end
          default: begin
          end
        endcase
        warn                   = scan_res.warn | (pk && pk_sev == LVL_WARNING);
        res_nxt.master_warning = warn;
        res_nxt.master_caution = !warn && (scan_res.caut | (pk && pk_sev == LVL_CAUTION));
        state_nxt              = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      active_r    <= '0;
      latched_r   <= '0;
      acked_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      valid_r     <= valid_nxt;
      active_r    <= active_nxt;
      latched_r   <= latched_nxt;
      acked_r     <= acked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    key_r    <= key_nxt;
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_SCAN && cnt_r == '0)
    else $error("input transfer did not start a table walk");

  a_caution_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.master_caution |-> !out_data.master_warning)
    else $error("master caution shown together with master warning");

  a_full_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> !out_data.became_shown && !out_data.became_hidden)
    else $error("full table result carries a show or hide edge");

  a_update_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && cnt_r == LAST |=> state_r == S_UPDATE && !rd_vld_r)
    else $error("walk end did not lead to the update cycle");

endmodule
